// File: design/tlrf_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and defaults of the thick line frame rasteriser.
package tlrf_pkg;

   localparam int CRD_W      = 12;
   localparam int DW         = CRD_W + 1;
   localparam int NUM_W      = 2 * CRD_W + 2;
   localparam int QUO_W      = CRD_W;
   localparam int CMD_W      = 2;
   localparam int ROW_W      = 8;
   localparam int COL_W      = 8;
   localparam int COLOR_W    = 24;
   localparam int HEIGHT_W   = 9;
   localparam int WIDTH_W    = 9;
   localparam int BRUSH_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_BRUSH  = 32;

   localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(256);
   localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(256);
   localparam logic [BRUSH_W-1:0]  RST_BRUSH  = BRUSH_W'(1);
   localparam logic [COLOR_W-1:0]  RST_COLOR  = '0;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LINE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRUSH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR  = 2'd3;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// File: design/thick_line_raster_to_frame.sv
`timescale 1ns / 1ps
// Frame store with pixel access and a thick line rasteriser built around one memory.
//
//   Channel | Direction | Handshake              | Item
//   req     | in        | req_valid / req_stall  | command, pixel access, line endpoints
//   rsp     | out       | rsp_valid / rsp_stall  | completed command and read colour
//   csr     | in        | csr_we                 | register index and data
//
// A pixel write, a pixel read or an unused command goes from idle to the final state. A
// line passes setup and a multiply step, then for each point on its major axis a load, a
// division, a point step and a next step, with one write for every brush pixel inside the
// image, all pixel writes going through the single memory port one at a time. A line with
// equal endpoints skips the division and stamps its brush once. The final state registers
// the result once the output is free. Reset acts only on the control state, the result flag
// and the settings; the frame store keeps its contents. A stalled result holds the block in
// its final state, while a new item may be accepted as soon as the result is registered.
module thick_line_raster_to_frame
   import tlrf_pkg::*;
#(
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_BRUSH  = DEF_MAX_BRUSH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [ROW_W-1:0]        req_pixel_row,
   input  logic [COL_W-1:0]        req_pixel_col,
   input  logic [COLOR_W-1:0]      req_pixel_value,
   input  logic signed [CRD_W-1:0] req_start_x,
   input  logic signed [CRD_W-1:0] req_start_y,
   input  logic signed [CRD_W-1:0] req_end_x,
   input  logic signed [CRD_W-1:0] req_end_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CMD_W-1:0]        rsp_done_kind,
   output logic [COLOR_W-1:0]      rsp_read_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RB        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CB        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int HB        = $clog2(MAX_HEIGHT + 1);
   localparam int WB        = $clog2(MAX_WIDTH + 1);
   localparam int BB        = $clog2(MAX_BRUSH + 1);
   localparam int EW        = imax(imax(DW, HB), imax(WB, BB)) + 2;
   localparam int ADDR_W    = RB + CB;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int CNT_W     = $clog2(QUO_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_POINT,
      ST_BRUSH,
      ST_NEXT,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [HEIGHT_W-1:0] height_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [BRUSH_W-1:0]  brush_ff;
   logic [COLOR_W-1:0]  color_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]    rsp_done_kind_ff, rsp_done_kind_in;
   logic [COLOR_W-1:0]  rsp_read_data_ff, rsp_read_data_in;

   logic [CMD_W-1:0]        kind_ff, kind_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic signed [CRD_W-1:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic                    xmaj_ff, xmaj_in;
   logic                    zero_ff, zero_in;
   logic signed [CRD_W-1:0] m_ff, m_in, me_ff, me_in, ns_ff, ns_in;
   logic [CRD_W-1:0]        dmaj_ff, dmaj_in;
   logic signed [DW-1:0]    dmin_ff, dmin_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic                    neg_ff, neg_in;
   logic [CRD_W-1:0]        rem_ff, rem_in, nlo_ff, nlo_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [RB-1:0]           t_ff, t_in, tend_ff, tend_in, hm1_ff, hm1_in;
   logic [CB-1:0]           p_ff, p_in, plo_ff, plo_in, pend_ff, pend_in;

   logic [COLOR_W-1:0] frame_store_mem [0:MEM_DEPTH-1];
   logic [COLOR_W-1:0] rd_data_ff;
   logic               mem_we, mem_re;
   logic [RB-1:0]      mem_row;
   logic [CB-1:0]      mem_col;
   logic [COLOR_W-1:0] mem_wdata;

   logic                    accept, pix_ok, rsp_free;
   logic signed [DW-1:0]    dx, dy, adx, ady;
   logic                    swap_x, swap_y;
   logic signed [2*CRD_W:0] prod;
   logic signed [NUM_W-1:0] mag;
   logic [CRD_W:0]          trial, diff;
   logic                    ge;
   logic signed [DW-1:0]    minor;
   logic signed [EW-1:0]    h_s, w_s, b_s, half, vx, hy, t0, p0, tlo, thi, plo, phi;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_done_kind = rsp_done_kind_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign pix_ok    = (32'(req_pixel_row) < MAX_HEIGHT) && (32'(req_pixel_col) < MAX_WIDTH);

   assign h_s  = (EW'(height_ff) > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : EW'(height_ff);
   assign w_s  = (EW'(width_ff) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_ff);
   assign b_s  = (EW'(brush_ff) > EW'(MAX_BRUSH)) ? EW'(MAX_BRUSH) : EW'(brush_ff);
   assign half = b_s >>> 1;

   assign dx     = DW'(x2_ff) - DW'(x1_ff);
   assign dy     = DW'(y2_ff) - DW'(y1_ff);
   assign adx    = dx[DW-1] ? -dx : dx;
   assign ady    = dy[DW-1] ? -dy : dy;
   assign swap_x = x1_ff > x2_ff;
   assign swap_y = y1_ff > y2_ff;

   assign prod = ns_ff * $signed({1'b0, dmaj_ff});
   assign mag  = num_ff[NUM_W-1] ? -num_ff : num_ff;

   assign trial = {rem_ff, nlo_ff[CRD_W-1]};
   assign ge    = trial >= {1'b0, dmaj_ff};
   assign diff  = trial - {1'b0, dmaj_ff};

   assign minor = zero_ff ? DW'(ns_ff) : (neg_ff ? -$signed({1'b0, quo_ff})
                                                 : $signed({1'b0, quo_ff}));
   assign vx  = xmaj_ff ? EW'(m_ff) : EW'(minor);
   assign hy  = xmaj_ff ? EW'(minor) : EW'(m_ff);
   assign t0  = vx - half;
   assign p0  = hy - half;
   assign tlo = t0[EW-1] ? '0 : t0;
   assign plo = p0[EW-1] ? '0 : p0;
   assign thi = ((t0 + b_s) > h_s) ? h_s : (t0 + b_s);
   assign phi = ((p0 + b_s) > w_s) ? w_s : (p0 + b_s);

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_done_kind_in = rsp_done_kind_ff;
      rsp_read_data_in = rsp_read_data_ff;
      kind_in  = kind_ff;
      rd_ok_in = rd_ok_ff;
      x1_in    = x1_ff;
      y1_in    = y1_ff;
      x2_in    = x2_ff;
      y2_in    = y2_ff;
      xmaj_in  = xmaj_ff;
      zero_in  = zero_ff;
      m_in     = m_ff;
      me_in    = me_ff;
      ns_in    = ns_ff;
      dmaj_in  = dmaj_ff;
      dmin_in  = dmin_ff;
      num_in   = num_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      nlo_in   = nlo_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      t_in     = t_ff;
      tend_in  = tend_ff;
      hm1_in   = hm1_ff;
      p_in     = p_ff;
      plo_in   = plo_ff;
      pend_in  = pend_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_row   = RB'(req_pixel_row);
      mem_col   = CB'(req_pixel_col);
      mem_wdata = req_pixel_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_cmd;
               rd_ok_in = pix_ok;
               x1_in    = req_start_x;
               y1_in    = req_start_y;
               x2_in    = req_end_x;
               y2_in    = req_end_y;
               mem_we   = (req_cmd == CMD_WRITE) && pix_ok;
               mem_re   = (req_cmd == CMD_READ) && pix_ok;
               state_in = (req_cmd == CMD_LINE) ? ST_SETUP : ST_RESP;
            end
         end
         ST_SETUP: begin
            xmaj_in = adx >= ady;
            if (adx >= ady) begin
               m_in    = swap_x ? x2_ff : x1_ff;
               me_in   = swap_x ? x1_ff : x2_ff;
               ns_in   = swap_x ? y2_ff : y1_ff;
               dmaj_in = adx[CRD_W-1:0];
               dmin_in = swap_x ? -dy : dy;
            end else begin
               m_in    = swap_y ? y2_ff : y1_ff;
               me_in   = swap_y ? y1_ff : y2_ff;
               ns_in   = swap_y ? x2_ff : x1_ff;
               dmaj_in = ady[CRD_W-1:0];
               dmin_in = swap_y ? -dx : dx;
            end
            zero_in  = (adx == '0) && (ady == '0);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            num_in   = NUM_W'(prod);
            state_in = zero_ff ? ST_POINT : ST_LOAD;
         end
         ST_LOAD: begin
            neg_in   = num_ff[NUM_W-1];
            rem_in   = mag[2*CRD_W-1:CRD_W];
            nlo_in   = mag[CRD_W-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? diff[CRD_W-1:0] : trial[CRD_W-1:0];
            nlo_in = nlo_ff << 1;
            quo_in = {quo_ff[QUO_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            t_in     = RB'(tlo);
            tend_in  = RB'(thi - 1);
            hm1_in   = RB'(h_s - 1);
            p_in     = CB'(plo);
            plo_in   = CB'(plo);
            pend_in  = CB'(phi - 1);
            state_in = ((tlo < thi) && (plo < phi)) ? ST_BRUSH : ST_NEXT;
         end
         ST_BRUSH: begin
            mem_we    = 1'b1;
            mem_row   = hm1_ff - t_ff;
            mem_col   = p_ff;
            mem_wdata = color_ff;
            if (p_ff == pend_ff) begin
               p_in = plo_ff;
               t_in = t_ff + RB'(1);
               if (t_ff == tend_ff) begin
                  state_in = ST_NEXT;
               end
            end else begin
               p_in = p_ff + CB'(1);
            end
         end
         ST_NEXT: begin
            if (zero_ff || (m_ff == me_ff)) begin
               state_in = ST_RESP;
            end else begin
               m_in     = m_ff + CRD_W'(1);
               num_in   = num_ff + NUM_W'(dmin_ff);
               state_in = ST_LOAD;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_done_kind_in = kind_ff;
               rsp_read_data_in = ((kind_ff == CMD_READ) && rd_ok_ff) ? rd_data_ff : '0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         height_ff    <= RST_HEIGHT;
         width_ff     <= RST_WIDTH;
         brush_ff     <= RST_BRUSH;
         color_ff     <= RST_COLOR;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_done_kind_ff <= rsp_done_kind_in;
         rsp_read_data_ff <= rsp_read_data_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
               CSR_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
               CSR_BRUSH:  brush_ff  <= csr_wdata[BRUSH_W-1:0];
               CSR_COLOR:  color_ff  <= csr_wdata[COLOR_W-1:0];
               default:    height_ff <= height_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      rd_ok_ff <= rd_ok_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      x2_ff    <= x2_in;
      y2_ff    <= y2_in;
      xmaj_ff  <= xmaj_in;
      zero_ff  <= zero_in;
      m_ff     <= m_in;
      me_ff    <= me_in;
      ns_ff    <= ns_in;
      dmaj_ff  <= dmaj_in;
      dmin_ff  <= dmin_in;
      num_ff   <= num_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      nlo_ff   <= nlo_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      t_ff     <= t_in;
      tend_ff  <= tend_in;
      hm1_ff   <= hm1_in;
      p_ff     <= p_in;
      plo_ff   <= plo_in;
      pend_ff  <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store_mem[{mem_row, mem_col}] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= frame_store_mem[{mem_row, mem_col}];
      end
   end

   a_rsp_from_final_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the final state");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !(req_valid && !req_stall) |=> (state_ff == ST_IDLE))
      else $error("left idle without an accepted item");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dmaj_ff))
      else $error("division remainder not below the divisor");

   a_brush_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BRUSH) |-> (32'(mem_row) < MAX_HEIGHT) && (32'(mem_col) < 32'(w_s)))
      else $error("brush write outside the image");

endmodule

// File: tb/thick_line_raster_to_frame_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the thick line frame rasteriser.
module thick_line_raster_to_frame_tb;
   import tlrf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int FRAME_ROWS    = DEF_MAX_HEIGHT;
   localparam int FRAME_COLS    = DEF_MAX_WIDTH;
   localparam int BRUSH_LIMIT   = DEF_MAX_BRUSH;
   localparam int FRAME_CELLS   = FRAME_ROWS * FRAME_COLS;
   localparam int COORD_MIN     = -(1 << (CRD_W - 1));
   localparam int COORD_MAX     = (1 << (CRD_W - 1)) - 1;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      logic [CMD_W-1:0]        cmd;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic [COLOR_W-1:0]      value;
      logic signed [CRD_W-1:0] sx;
      logic signed [CRD_W-1:0] sy;
      logic signed [CRD_W-1:0] ex;
      logic signed [CRD_W-1:0] ey;
   } frame_op_type;

   typedef struct {
      logic [CMD_W-1:0]   kind;
      logic [COLOR_W-1:0] data;
   } frame_done_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_cmd = CMD_WRITE;
   logic [ROW_W-1:0]        req_pixel_row = '0;
   logic [COL_W-1:0]        req_pixel_col = '0;
   logic [COLOR_W-1:0]      req_pixel_value = '0;
   logic signed [CRD_W-1:0] req_start_x = '0;
   logic signed [CRD_W-1:0] req_start_y = '0;
   logic signed [CRD_W-1:0] req_end_x = '0;
   logic signed [CRD_W-1:0] req_end_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [CMD_W-1:0]        rsp_done_kind;
   logic [COLOR_W-1:0]      rsp_read_data;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_HEIGHT;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int                 shadow_height = int'(RST_HEIGHT);
   int                 shadow_width = int'(RST_WIDTH);
   int                 shadow_brush = int'(RST_BRUSH);
   logic [COLOR_W-1:0] shadow_color = RST_COLOR;
   logic [COLOR_W-1:0] frame_mirror [FRAME_CELLS];
   bit                 pixel_written [FRAME_CELLS];
   int                 written_pixels [$];
   frame_done_type     pending_done [$];

   int             fail_count = 0;
   int unsigned    burst_left = 0;
   bit             sender_gaps = 1'b1;
   int unsigned    hold_request = 0;
   int unsigned    hold_left = 0;
   int unsigned    mode_left = 0;
   int unsigned    cycle_count = 0;
   stall_mode_type stall_mode = STALL_NONE;

   thick_line_raster_to_frame u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pixel_row   (req_pixel_row),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_value (req_pixel_value),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_done_kind   (rsp_done_kind),
      .rsp_read_data   (rsp_read_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void store_pixel(input int idx, input logic [COLOR_W-1:0] value);
      frame_mirror[idx] = value;
      if (!pixel_written[idx]) begin
         pixel_written[idx] = 1'b1;
         written_pixels.push_back(idx);
      end
   endfunction

   function automatic void stamp_brush(input int vx, input int hy);
      int h, w, b, half, t0, p0, tlo, thi, plo, phi;
      h = (shadow_height > FRAME_ROWS) ? FRAME_ROWS : shadow_height;
      w = (shadow_width > FRAME_COLS) ? FRAME_COLS : shadow_width;
      b = (shadow_brush > BRUSH_LIMIT) ? BRUSH_LIMIT : shadow_brush;
      half = b / 2;
      t0 = vx - half;
      p0 = hy - half;
      tlo = (t0 < 0) ? 0 : t0;
      thi = (t0 + b > h) ? h : t0 + b;
      plo = (p0 < 0) ? 0 : p0;
      phi = (p0 + b > w) ? w : p0 + b;
      for (int t = tlo; t < thi; t++)
         for (int p = plo; p < phi; p++)
            store_pixel((h - 1 - t) * FRAME_COLS + p, shadow_color);
   endfunction

   function automatic void trace_line(input int x1, input int y1, input int x2, input int y2);
      int ax, ay, dx, dy, tmp;
      bit x_major;
      ax = (x2 > x1) ? x2 - x1 : x1 - x2;
      ay = (y2 > y1) ? y2 - y1 : y1 - y2;
      x_major = (ax >= ay);
      if (x_major ? (x1 > x2) : (y1 > y2)) begin
         tmp = x1; x1 = x2; x2 = tmp;
         tmp = y1; y1 = y2; y2 = tmp;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      if (x_major) begin
         if (dx == 0)
            stamp_brush(x1, y1);
         else
            for (int m = x1; m <= x2; m++)
               stamp_brush(m, ((m - x1) * dy + y1 * dx) / dx);
      end else begin
         for (int m = y1; m <= y2; m++)
            stamp_brush(((m - y1) * dx + x1 * dy) / dy, m);
      end
   endfunction

   function automatic frame_done_type apply_frame_op(input frame_op_type op);
      frame_done_type done;
      done.kind = op.cmd;
      done.data = '0;
      case (op.cmd)
         CMD_WRITE: store_pixel(int'({op.row, op.col}), op.value);
         CMD_READ:  done.data = frame_mirror[int'({op.row, op.col})];
         CMD_LINE:  trace_line(int'(op.sx), int'(op.sy), int'(op.ex), int'(op.ey));
         default:   ;
      endcase
      return done;
   endfunction

   function automatic frame_op_type scatter_op(input logic [CMD_W-1:0] cmd);
      frame_op_type op;
      op.cmd = cmd;
      op.row = ROW_W'($urandom);
      op.col = COL_W'($urandom);
      op.value = COLOR_W'($urandom);
      op.sx = CRD_W'($urandom);
      op.sy = CRD_W'($urandom);
      op.ex = CRD_W'($urandom);
      op.ey = CRD_W'($urandom);
      return op;
   endfunction

   function automatic frame_op_type make_pixel(input logic [CMD_W-1:0] cmd, input int row,
                                               input int col, input logic [COLOR_W-1:0] value);
      frame_op_type op;
      op = scatter_op(cmd);
      op.row = ROW_W'(row);
      op.col = COL_W'(col);
      op.value = value;
      return op;
   endfunction

   function automatic frame_op_type make_line(input int x1, input int y1, input int x2,
                                              input int y2);
      frame_op_type op;
      op = scatter_op(CMD_LINE);
      op.sx = CRD_W'(x1);
      op.sy = CRD_W'(y1);
      op.ex = CRD_W'(x2);
      op.ey = CRD_W'(y2);
      return op;
   endfunction

   function automatic frame_op_type revisit_op();
      frame_op_type op;
      int idx;
      if (written_pixels.size() == 0)
         return scatter_op(CMD_WRITE);
      op = scatter_op(CMD_READ);
      idx = written_pixels[$urandom_range(0, written_pixels.size() - 1)];
      op.row = idx[15:8];
      op.col = idx[7:0];
      return op;
   endfunction

   function automatic int fit_coord(input int v);
      return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   function automatic frame_op_type random_line();
      int x1, y1, x2, y2;
      if ($urandom_range(0, 7) == 0) begin
         x1 = int'($urandom_range(0, 4095)) + COORD_MIN;
         y1 = int'($urandom_range(0, 4095)) + COORD_MIN;
      end else begin
         x1 = int'($urandom_range(0, 279)) - 12;
         y1 = int'($urandom_range(0, 279)) - 12;
      end
      if ($urandom_range(0, 9) == 0) begin
         x2 = x1;
         y2 = y1;
      end else begin
         x2 = fit_coord(x1 + int'($urandom_range(0, 32)) - 16);
         y2 = fit_coord(y1 + int'($urandom_range(0, 32)) - 16);
      end
      return make_line(x1, y1, x2, y2);
   endfunction

   function automatic frame_op_type random_op();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         return scatter_op(CMD_WRITE);
      if (pick < 65)
         return revisit_op();
      if (pick < 95)
         return random_line();
      return scatter_op(CMD_SPARE);
   endfunction

   task automatic push_item(input frame_op_type op);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = (sender_gaps && $urandom_range(0, 1) == 1) ? $urandom_range(1, 6) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_cmd         <= op.cmd;
      req_pixel_row   <= op.row;
      req_pixel_col   <= op.col;
      req_pixel_value <= op.value;
      req_start_x     <= op.sx;
      req_start_y     <= op.sy;
      req_end_x       <= op.ex;
      req_end_y       <= op.ey;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_done.push_back(apply_frame_op(op));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_done.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input int unsigned height, input int unsigned width,
                           input int unsigned brush, input logic [COLOR_W-1:0] color);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_HEIGHT;
      csr_wdata <= CSR_DATA_W'(height);
      @(posedge clock);
      csr_index <= CSR_WIDTH;
      csr_wdata <= CSR_DATA_W'(width);
      @(posedge clock);
      csr_index <= CSR_BRUSH;
      csr_wdata <= CSR_DATA_W'(brush);
      @(posedge clock);
      csr_index <= CSR_COLOR;
      csr_wdata <= color;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_height = int'(height[HEIGHT_W-1:0]);
      shadow_width  = int'(width[WIDTH_W-1:0]);
      shadow_brush  = int'(brush[BRUSH_W-1:0]);
      shadow_color  = color;
   endtask

   task automatic test_pixel_access();
      push_item(make_pixel(CMD_WRITE, 0, 0, 24'h000000));
      push_item(make_pixel(CMD_WRITE, 255, 255, 24'hFFFFFF));
      push_item(make_pixel(CMD_WRITE, 0, 255, 24'hA5A5A5));
      push_item(make_pixel(CMD_WRITE, 255, 0, 24'h5A5A5A));
      push_item(make_pixel(CMD_READ, 0, 0, 24'hFFFFFF));
      push_item(make_pixel(CMD_READ, 255, 255, 24'h000000));
      push_item(make_pixel(CMD_READ, 0, 255, 24'h000000));
      push_item(make_pixel(CMD_READ, 255, 0, 24'hFFFFFF));
      push_item(make_pixel(CMD_SPARE, 255, 255, 24'hFFFFFF));
   endtask

   task automatic test_line_extremes();
      set_regs(256, 256, 1, 24'h123456);
      push_item(make_line(7, 9, 7, 9));
      push_item(make_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      push_item(make_line(100, COORD_MAX, -100, COORD_MIN));
      push_item(make_line(60, 30, 10, 5));
      push_item(revisit_op());
      push_item(revisit_op());
   endtask

   task automatic test_register_limits();
      set_regs(0, 256, 3, 24'hFF0000);
      push_item(make_line(10, 10, 20, 14));
      set_regs(256, 0, 3, 24'h00FF00);
      push_item(make_line(10, 10, 20, 14));
      set_regs(256, 256, 0, 24'h0000FF);
      push_item(make_line(10, 10, 20, 14));
      set_regs(511, 511, 2, 24'hFFFFFF);
      push_item(make_line(250, 250, 260, 253));
      set_regs(1, 1, 1, 24'h000000);
      push_item(make_line(-3, -3, 3, 3));
      set_regs(256, 256, 63, 24'hC3C3C3);
      push_item(make_line(100, 100, 101, 102));
      set_regs(20, 30, 33, 24'h3C3C3C);
      push_item(make_line(0, 0, 3, 2));
      push_item(make_pixel(CMD_READ, 0, 0, 24'h000000));
      push_item(revisit_op());
      push_item(revisit_op());
   endtask

   task automatic test_backpressure();
      set_regs(256, 256, 2, 24'h808080);
      sender_gaps = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (20) push_item(($urandom_range(0, 1) == 0) ? scatter_op(CMD_WRITE) : revisit_op());
      wait_idle();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_regs(256, 256, 1, 24'($urandom));
            1: set_regs($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(0, 5),
                        24'($urandom));
            2: set_regs($urandom_range(257, 511), $urandom_range(257, 511), 2, 24'($urandom));
            3: set_regs($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 4),
                        24'($urandom));
            4: set_regs((24'($urandom) & ~24'h1FF) | $urandom_range(1, 256),
                        (24'($urandom) & ~24'h1FF) | $urandom_range(1, 256),
                        (24'($urandom) & ~24'h3F) | $urandom_range(0, 4), 24'($urandom));
            default: set_regs(256, 256, 3, 24'($urandom));
         endcase
         sender_gaps = (phase % 2) == 1;
         repeat (90) push_item(random_op());
      end
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(64, 256);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((cycle_count % 5) < 2);
         endcase
      end
      cycle_count++;
   end

   always @(posedge clock) begin
      frame_done_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_done.size() == 0) begin
            $error("done_kind: no result expected, got %0d", rsp_done_kind);
            fail_count++;
         end else begin
            want = pending_done.pop_front();
            if (rsp_done_kind !== want.kind) begin
               $error("done_kind: expected %0d, got %0d", want.kind, rsp_done_kind);
               fail_count++;
            end
            if (rsp_read_data !== want.data) begin
               $error("read_data: expected %06h, got %06h", want.data, rsp_read_data);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #(50_000_000);
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pixel_access();
      test_line_extremes();
      test_register_limits();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: thick_line_raster_to_frame.f
design/tlrf_pkg.sv
design/thick_line_raster_to_frame.sv
tb/thick_line_raster_to_frame_tb.sv
